// ===== rtl/core/brl_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

	localparam int COORD_BITS = 12;
	localparam int WIDTH_BITS = 13;
	localparam int ERR_BITS = COORD_BITS + 2;
	localparam int ADDR_BITS = 26;
	localparam int PROD_BITS = COORD_BITS + WIDTH_BITS;
	localparam int COLOR_BITS = 32;
	localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(1024);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	// One classified item, with line setup precomputed for loads.
	typedef struct packed {
		op_t                   op;
		coord_t                start_x;
		coord_t                start_y;
		coord_t                end_x;
		coord_t                end_y;
		coord_t                delta_x;
		coord_t                delta_y;
		logic                  step_x_neg;
		logic                  step_y_neg;
		err_t                  seed;
		logic                  single_point;
		logic [COLOR_BITS-1:0] color;
	} queue_entry_t;

endpackage

// ===== rtl/core/brl_front.sv =====
// Front end: accepts items, classifies them and computes the line setup.
`timescale 1ns / 1ps

module brl_front (
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  brl_pkg::coord_t                start_x,
	input  brl_pkg::coord_t                start_y,
	input  brl_pkg::coord_t                end_x,
	input  brl_pkg::coord_t                end_y,
	input  logic [brl_pkg::COLOR_BITS-1:0] line_color,
	input  logic                           q_full,
	output logic                           q_push,
	output brl_pkg::queue_entry_t          q_entry
);

	brl_pkg::coord_t dx;
	brl_pkg::coord_t dy;
	brl_pkg::err_t   half_dx;
	brl_pkg::err_t   half_dy;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		dx = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
		dy = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
		half_dx = brl_pkg::err_t'({2'b00, dx >> 1});
		half_dy = brl_pkg::err_t'({2'b00, dy >> 1});

		q_entry.op = (operation == 1'b1) ? brl_pkg::OP_STEP : brl_pkg::OP_LOAD;
		q_entry.start_x = start_x;
		q_entry.start_y = start_y;
		q_entry.end_x = end_x;
		q_entry.end_y = end_y;
		q_entry.delta_x = dx;
		q_entry.delta_y = dy;
		q_entry.step_x_neg = !(start_x < end_x);
		q_entry.step_y_neg = !(start_y < end_y);
		// seed halved toward zero
		q_entry.seed = (dx > dy) ? half_dx : -half_dy;
		q_entry.single_point = (start_x == end_x) && (start_y == end_y);
		q_entry.color = line_color;
	end

endmodule

// ===== rtl/core/brl_queue.sv =====
// Short queue between front end and stepper.
`timescale 1ns / 1ps

module brl_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  brl_pkg::queue_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output brl_pkg::queue_entry_t head_entry
);

	brl_pkg::queue_entry_t mem_q [brl_pkg::QUEUE_DEPTH];
	logic [brl_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [brl_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [brl_pkg::QCNT_BITS-1:0] count_q;

	localparam logic [brl_pkg::QPTR_BITS-1:0] LAST_PTR =
		brl_pkg::QPTR_BITS'(brl_pkg::QUEUE_DEPTH - 1);

	assign full = (count_q == brl_pkg::QCNT_BITS'(brl_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/brl_back.sv =====
// Back end: Bresenham stepper, address multiply and output register.
`timescale 1ns / 1ps

module brl_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brl_pkg::WIDTH_BITS-1:0] cfg_wdata,
	input  logic                           q_valid,
	input  brl_pkg::queue_entry_t          q_head,
	output logic                           q_pop,
	output logic                           pixel_valid,
	input  logic                           pixel_stall,
	output brl_pkg::coord_t                pixel_x,
	output brl_pkg::coord_t                pixel_y,
	output logic [brl_pkg::ADDR_BITS-1:0]  byte_address,
	output logic [brl_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                           last_pixel
);

	logic [brl_pkg::WIDTH_BITS-1:0] frame_width_q;

	// line state
	brl_pkg::coord_t                cur_x_q;
	brl_pkg::coord_t                cur_y_q;
	brl_pkg::coord_t                tgt_x_q;
	brl_pkg::coord_t                tgt_y_q;
	brl_pkg::coord_t                dx_q;
	brl_pkg::coord_t                dy_q;
	logic                           sxn_q;
	logic                           syn_q;
	brl_pkg::err_t                  err_q;
	logic [brl_pkg::COLOR_BITS-1:0] color_q;
	logic                           active_q;

	// pixel stage
	logic                           v_s1;
	brl_pkg::coord_t                x_s1;
	brl_pkg::coord_t                y_s1;
	logic [brl_pkg::COLOR_BITS-1:0] color_s1;
	logic                           last_s1;

	// multiply stage
	logic                           v_s2;
	brl_pkg::coord_t                x_s2;
	brl_pkg::coord_t                y_s2;
	logic [brl_pkg::PROD_BITS-1:0]  prod_s2;
	logic [brl_pkg::COLOR_BITS-1:0] color_s2;
	logic                           last_s2;

	// output register
	logic                           out_v_q;
	brl_pkg::coord_t                out_x_q;
	brl_pkg::coord_t                out_y_q;
	logic [brl_pkg::ADDR_BITS-1:0]  out_addr_q;
	logic [brl_pkg::COLOR_BITS-1:0] out_color_q;
	logic                           out_last_q;

	logic out_ready;
	logic s2_ready;
	logic s1_ready;
	logic is_load;
	logic emit;

	brl_pkg::err_t   dx_e;
	brl_pkg::err_t   dy_e;
	logic            move_x;
	logic            move_y;
	brl_pkg::coord_t nx;
	brl_pkg::coord_t ny;
	brl_pkg::err_t   nerr;
	logic [brl_pkg::ADDR_BITS-1:0] pix_index;

	assign out_ready = !out_v_q || !pixel_stall;
	assign s2_ready = !v_s2 || out_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign q_pop = q_valid && s1_ready;
	assign is_load = (q_head.op == brl_pkg::OP_LOAD);
	assign emit = q_pop && (is_load || active_q);

	always_comb begin
		dx_e = brl_pkg::err_t'({2'b00, dx_q});
		dy_e = brl_pkg::err_t'({2'b00, dy_q});
		move_x = (err_q > -dx_e);
		move_y = (err_q < dy_e);
		nerr = err_q;
		nx = cur_x_q;
		ny = cur_y_q;
		if (move_x) begin
			nerr = nerr - dy_e;
			nx = sxn_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		end
		if (move_y) begin
			nerr = nerr + dx_e;
			ny = syn_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= brl_pkg::FRAME_WIDTH_RESET;
		end else if (cfg_we) begin
			frame_width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			if (is_load) begin
				active_q <= !q_head.single_point;
			end else if (active_q) begin
				active_q <= !((nx == tgt_x_q) && (ny == tgt_y_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (is_load) begin
				cur_x_q <= q_head.start_x;
				cur_y_q <= q_head.start_y;
				tgt_x_q <= q_head.end_x;
				tgt_y_q <= q_head.end_y;
				dx_q <= q_head.delta_x;
				dy_q <= q_head.delta_y;
				sxn_q <= q_head.step_x_neg;
				syn_q <= q_head.step_y_neg;
				err_q <= q_head.seed;
				color_q <= q_head.color;
			end else if (active_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				err_q <= nerr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= emit;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (out_ready) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && emit) begin
			if (is_load) begin
				x_s1 <= q_head.start_x;
				y_s1 <= q_head.start_y;
				color_s1 <= q_head.color;
				last_s1 <= q_head.single_point;
			end else begin
				x_s1 <= nx;
				y_s1 <= ny;
				color_s1 <= color_q;
				last_s1 <= (nx == tgt_x_q) && (ny == tgt_y_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			prod_s2 <= brl_pkg::PROD_BITS'(y_s1) * brl_pkg::PROD_BITS'(frame_width_q);
			color_s2 <= color_s1;
			last_s2 <= last_s1;
		end
	end

	assign pix_index = brl_pkg::ADDR_BITS'(prod_s2) + brl_pkg::ADDR_BITS'(x_s2);

	always_ff @(posedge clk) begin
		if (out_ready && v_s2) begin
			out_x_q <= x_s2;
			out_y_q <= y_s2;
			out_addr_q <= {pix_index[brl_pkg::ADDR_BITS-3:0], 2'b00};
			out_color_q <= color_s2;
			out_last_q <= last_s2;
		end
	end

	assign pixel_valid = out_v_q;
	assign pixel_x = out_x_q;
	assign pixel_y = out_y_q;
	assign byte_address = out_addr_q;
	assign pixel_color = out_color_q;
	assign last_pixel = out_last_q;

endmodule

// ===== rtl/core/bresenham_line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer.
`timescale 1ns / 1ps

// Takes one item per cycle and gives one pixel per cycle while no stall holds
// the flow. A load (operation 0) latches endpoints and color and yields the
// first pixel; each step (operation 1) yields the next pixel of the line, with
// last_pixel set at the second endpoint, and a step with no line in progress
// yields nothing. A pixel passes through a two-entry queue, the error update
// stage, the row-times-width multiply stage and the output register. The
// sustained rate is set by the error and coordinate update in the stepper.
// byte_address is (pixel_y * frame_width + pixel_x) * 4, wrapped to 26 bits;
// there is no clipping. Write frame_width only while no pixels are pending.

module bresenham_line_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brl_pkg::WIDTH_BITS-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  brl_pkg::coord_t                start_x,
	input  brl_pkg::coord_t                start_y,
	input  brl_pkg::coord_t                end_x,
	input  brl_pkg::coord_t                end_y,
	input  logic [brl_pkg::COLOR_BITS-1:0] line_color,
	output logic                           pixel_valid,
	input  logic                           pixel_stall,
	output brl_pkg::coord_t                pixel_x,
	output brl_pkg::coord_t                pixel_y,
	output logic [brl_pkg::ADDR_BITS-1:0]  byte_address,
	output logic [brl_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                           last_pixel
);

	logic                  q_push;
	logic                  q_full;
	logic                  q_pop;
	logic                  q_valid;
	brl_pkg::queue_entry_t q_entry;
	brl_pkg::queue_entry_t q_head;

	brl_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_color (line_color),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	brl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_head)
	);

	brl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Bresenham line rasterizer.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_COORD = (1 << brl_pkg::COORD_BITS) - 1;

	typedef struct {
		brl_pkg::op_t                   op;
		brl_pkg::coord_t                sx;
		brl_pkg::coord_t                sy;
		brl_pkg::coord_t                ex;
		brl_pkg::coord_t                ey;
		logic [brl_pkg::COLOR_BITS-1:0] color;
	} line_cmd_t;

	typedef struct {
		brl_pkg::coord_t                x;
		brl_pkg::coord_t                y;
		logic [brl_pkg::ADDR_BITS-1:0]  addr;
		logic [brl_pkg::COLOR_BITS-1:0] color;
		logic                           last;
	} pixel_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [brl_pkg::WIDTH_BITS-1:0] cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           operation = 1'b0;
	brl_pkg::coord_t                start_x = '0;
	brl_pkg::coord_t                start_y = '0;
	brl_pkg::coord_t                end_x = '0;
	brl_pkg::coord_t                end_y = '0;
	logic [brl_pkg::COLOR_BITS-1:0] line_color = '0;
	logic                           pixel_valid;
	logic                           pixel_stall = 1'b0;
	brl_pkg::coord_t                pixel_x;
	brl_pkg::coord_t                pixel_y;
	logic [brl_pkg::ADDR_BITS-1:0]  byte_address;
	logic [brl_pkg::COLOR_BITS-1:0] pixel_color;
	logic                           last_pixel;

	bresenham_line_rasterizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.line_color   (line_color),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_cmd_t pending_cmds[$];
	pixel_t    expected_pixels[$];
	line_cmd_t cur_cmd;
	int        errors = 0;
	int        cycle_count = 0;

	// rasterizer state as the testbench sees it
	logic [brl_pkg::WIDTH_BITS-1:0] frame_w = brl_pkg::FRAME_WIDTH_RESET;
	brl_pkg::coord_t                cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
	brl_pkg::coord_t                dlt_x = '0, dlt_y = '0;
	logic                           neg_x = 1'b0, neg_y = 1'b0;
	int                             err = 0;
	logic [brl_pkg::COLOR_BITS-1:0] held_color = '0;
	logic                           active = 1'b0;

	function automatic void rasterize_cmd(line_cmd_t c);
		pixel_t px;
		int     e2;
		logic   last;
		if (c.op == brl_pkg::OP_LOAD) begin
			dlt_x = (c.ex > c.sx) ? c.ex - c.sx : c.sx - c.ex;
			dlt_y = (c.ey > c.sy) ? c.ey - c.sy : c.sy - c.ey;
			neg_x = !(c.sx < c.ex);
			neg_y = !(c.sy < c.ey);
			err = (dlt_x > dlt_y) ? int'(dlt_x) / 2 : -int'(dlt_y) / 2;
			cur_x = c.sx;
			cur_y = c.sy;
			tgt_x = c.ex;
			tgt_y = c.ey;
			held_color = c.color;
			last = (c.sx == c.ex) && (c.sy == c.ey);
			active = !last;
		end else begin
			if (!active)
				return;
			e2 = err;
			if (e2 > -int'(dlt_x)) begin
				err -= int'(dlt_y);
				cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
			end
			if (e2 < int'(dlt_y)) begin
				err += int'(dlt_x);
				cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
			end
			last = (cur_x == tgt_x) && (cur_y == tgt_y);
			if (last)
				active = 1'b0;
		end
		px.x = cur_x;
		px.y = cur_y;
		px.addr = brl_pkg::ADDR_BITS'((longint'(cur_y) * longint'(frame_w)
			+ longint'(cur_x)) * 4);
		px.color = held_color;
		px.last = last;
		expected_pixels.push_back(px);
	endfunction

	// sender: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : driver
		logic holding;
		if (arst_n) begin
			holding = in_valid;
			if (in_valid && !in_stall) begin
				rasterize_cmd(cur_cmd);
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					holding = 1'b1;
					operation <= cur_cmd.op;
					start_x <= cur_cmd.sx;
					start_y <= cur_cmd.sy;
					end_x <= cur_cmd.ex;
					end_y <= cur_cmd.ey;
					line_color <= cur_cmd.color;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
			in_valid <= holding;
		end
	end

	// receiver: its own stall pattern, plus two long hold-offs
	int drained = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk) begin : receiver
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				drained++;
				if (drained == 150 || drained == 900)
					hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				pixel_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 200);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: pixel_stall <= 1'b0;
					1: pixel_stall <= 1'($urandom_range(0, 1));
					2: pixel_stall <= ($urandom_range(0, 7) == 0);
					default: pixel_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		pixel_t want;
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected pixel x=%0d y=%0d addr=%h color=%h last=%b",
						pixel_x, pixel_y, byte_address, pixel_color, last_pixel);
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_x !== want.x || pixel_y !== want.y || byte_address !== want.addr ||
						pixel_color !== want.color || last_pixel !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %0d,%0d %h %h %b got %0d,%0d %h %h %b",
							want.x, want.y, want.addr, want.color, want.last,
							pixel_x, pixel_y, byte_address, pixel_color, last_pixel);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[bresenham_line_rasterizer] ERROR");
			$finish;
		end
	end

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
	endfunction

	function automatic int pick_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? MAX_COORD : 0;
		return $urandom_range(0, MAX_COORD);
	endfunction

	task automatic queue_line(int sx, int sy, int ex, int ey, logic [31:0] color, int nsteps);
		pending_cmds.push_back('{brl_pkg::OP_LOAD, brl_pkg::coord_t'(sx),
			brl_pkg::coord_t'(sy), brl_pkg::coord_t'(ex), brl_pkg::coord_t'(ey), color});
		repeat (nsteps)
			pending_cmds.push_back('{brl_pkg::OP_STEP, brl_pkg::coord_t'($urandom),
				brl_pkg::coord_t'($urandom), brl_pkg::coord_t'($urandom),
				brl_pkg::coord_t'($urandom), $urandom});
	endtask

	task automatic add_random_lines(int budget);
		int made, sx, sy, ex, ey, span, len, nsteps, ax, ay;
		made = 0;
		while (made < budget) begin
			sx = pick_coord();
			sy = pick_coord();
			span = ($urandom_range(0, 39) == 0) ? 300 : 10;
			ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
			ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
			case ($urandom_range(0, 11))
				0: ey = sy;
				1: ex = sx;
				2: ey = clamp_coord(sy + ($urandom_range(0, 1) ? 1 : -1) *
					((ex > sx) ? ex - sx : sx - ex));
				3: begin
					ex = sx;
					ey = sy;
				end
				default: ;
			endcase
			ax = (ex > sx) ? ex - sx : sx - ex;
			ay = (ey > sy) ? ey - sy : sy - ey;
			len = (ax > ay) ? ax : ay;
			case ($urandom_range(0, 9))
				0: nsteps = $urandom_range(0, len);
				1: nsteps = len + $urandom_range(1, 3);
				default: nsteps = len;
			endcase
			queue_line(sx, sy, ex, ey, $urandom, nsteps);
			made += 1 + ((nsteps < len) ? nsteps : len);
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		// steps past the end of a line leave no expectation behind
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_width(logic [brl_pkg::WIDTH_BITS-1:0] w);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_w = w;
	endtask

	logic [brl_pkg::WIDTH_BITS-1:0] widths[5];

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// step with nothing loaded, single points at both corners
		queue_line(0, 0, 0, 0, 32'h0000_0000, 0);
		pending_cmds.push_front('{brl_pkg::OP_STEP, brl_pkg::coord_t'(MAX_COORD),
			brl_pkg::coord_t'(MAX_COORD), brl_pkg::coord_t'(MAX_COORD),
			brl_pkg::coord_t'(MAX_COORD), 32'hFFFF_FFFF});
		queue_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF, 0);
		queue_line(0, 0, MAX_COORD, MAX_COORD, 32'h0123_4567, 3);
		// anti-diagonal dropped by the next load
		queue_line(MAX_COORD, 0, 0, MAX_COORD, 32'h89AB_CDEF, 2);
		// horizontal, one extra step after the end
		queue_line(10, 10, 13, 10, 32'hA5A5_5A5A, 4);
		queue_line(20, 25, 20, 21, 32'h5A5A_A5A5, 4);
		queue_line(100, 100, 95, 102, 32'hDEAD_BEEF, 5);
		add_random_lines(250);

		widths = '{13'd1, 13'd4096, 13'd0, 13'd8191,
			brl_pkg::WIDTH_BITS'($urandom_range(1, 4096))};
		foreach (widths[i]) begin
			wait_idle();
			write_frame_width(widths[i]);
			add_random_lines(265);
		end

		wait_idle();
		if (errors == 0 && expected_pixels.size() == 0)
			$display("[bresenham_line_rasterizer] OK");
		else
			$display("[bresenham_line_rasterizer] ERROR");
		$finish;
	end

endmodule
